### src/rmsu_pkg.sv
// ----------------------------------------------------------------------------
// rmsu_pkg
// Shared types and constants for the road merge and stub union block.
// ----------------------------------------------------------------------------
package rmsu_pkg;

  // Field widths fixed by the stream format
  localparam int unsigned OP_W      = 3;
  localparam int unsigned INDEX_W   = 16;
  localparam int unsigned REF_W     = 12;
  localparam int unsigned INVPT_W   = 16;
  localparam int unsigned FREQ_W    = 24;
  localparam int unsigned TOWER_W   = 6;
  localparam int unsigned LAYER_W   = 3;
  localparam int unsigned NSTUBS_W  = 5;

  // Packed stream widths
  localparam int unsigned IN_TDATA_W  = 96;
  localparam int unsigned IN_TUSER_W  = 3;
  localparam int unsigned OUT_TDATA_W = 80;
  localparam int unsigned OUT_TUSER_W = 2;

  // Occupancy bitmap word
  localparam int unsigned OCC_W  = 32;
  localparam int unsigned OCC_BW = 5;

  // Request kinds
  typedef enum logic [OP_W-1:0] {
    OP_LOAD_MAP  = 3'd0,
    OP_LOAD_ATTR = 3'd1,
    OP_HEADER    = 3'd2,
    OP_STUB      = 3'd3,
    OP_DRAIN     = 3'd4,
    OP_CLEAR     = 3'd5
  } op_e;

  // Sequencer states
  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_HDR_MAP,
    S_HDR_OCC,
    S_HDR_CLR,
    S_STUB,
    S_SCAN,
    S_FETCH,
    S_SUM,
    S_EMIT,
    S_EMPTY,
    S_NONE
  } state_e;

endpackage

### src/rmsu_ram.sv
// ----------------------------------------------------------------------------
// rmsu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rmsu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/rmsu_ffs.sv
// ----------------------------------------------------------------------------
// rmsu_ffs
// Find first set: lowest set bit of an occupancy word.
// ----------------------------------------------------------------------------
module rmsu_ffs (
  input  logic [rmsu_pkg::OCC_W-1:0]  word_i,
  output logic                        found_o,
  output logic [rmsu_pkg::OCC_BW-1:0] idx_o
);
  import rmsu_pkg::*;

  // Priority encoder, lowest bit wins
  always_comb begin
    idx_o = '0;
    for (int i = OCC_W - 1; i >= 0; i--) begin
      if (word_i[i]) begin
        idx_o = OCC_BW'(i);
      end
    end
  end

  assign found_o = |word_i;

endmodule

### src/road_merge_stub_union.sv
// Timing: map/attr loads are written as they are accepted; a stub reads its row and writes it back,
// unless ignored; a header reads the map, then the bitmap, and clears one list per layer when it opens a slot.
// A drain scans the occupancy bitmap one 32-bit word a cycle, sums LAYERS rows, then gives
// one result a cycle per stub while the output is not stalled, reading the next layer row between lists.
// Reset and clear (op 5) run a pass over the bitmap, while no request is accepted.
// Depths are powers of two.
// ----------------------------------------------------------------------------
// road_merge_stub_union
// Merges roads sharing a merged pattern into one slot and unions their stubs.
// ----------------------------------------------------------------------------
module road_merge_stub_union #(
  parameter int unsigned PATTERN_DEPTH = 65536,
  parameter int unsigned MERGED_DEPTH  = 4096,
  parameter int unsigned LAYERS        = 6,
  parameter int unsigned MAX_STUBS     = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // index, merged_ref, inv_pt, frequency, tower, layer, stub_ref (lowest first)
  input  logic [rmsu_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // op
  input  logic [rmsu_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // out_merged_ref, out_tower, out_nstubs, out_inv_pt, out_frequency,
  // out_layer, out_stub_ref (lowest first)
  output logic [rmsu_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // stub_valid, done_res (lowest first)
  output logic [rmsu_pkg::OUT_TUSER_W-1:0]  m_axis_tuser,
  output logic                              m_axis_tlast
);
  import rmsu_pkg::*;

  localparam int unsigned PAW    = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
  localparam int unsigned MW     = $clog2(MERGED_DEPTH);
  localparam int unsigned LW     = (LAYERS > 1) ? $clog2(LAYERS) : 1;
  localparam int unsigned ODEPTH = (MERGED_DEPTH + OCC_W - 1) / OCC_W;
  localparam int unsigned OAW    = (ODEPTH > 1) ? $clog2(ODEPTH) : 1;
  localparam int unsigned EW     = OAW + OCC_BW;
  localparam int unsigned CW     = $clog2(MAX_STUBS + 1);
  localparam int unsigned RW     = CW + MAX_STUBS * REF_W;
  localparam int unsigned TW     = $clog2(LAYERS * MAX_STUBS + 1);
  localparam int unsigned DPW    = $clog2(MERGED_DEPTH + 1);
  localparam int unsigned RAW    = MW + LW;
  localparam int unsigned RDEPTH = MERGED_DEPTH << LW;
  localparam int unsigned ATTR_W = INVPT_W + FREQ_W;

  // Input field split
  logic [OP_W-1:0]    in_op;
  logic [INDEX_W-1:0] in_index;
  logic [REF_W-1:0]   in_merged_ref;
  logic [INVPT_W-1:0] in_inv_pt;
  logic [FREQ_W-1:0]  in_freq;
  logic [TOWER_W-1:0] in_tower;
  logic [LAYER_W-1:0] in_layer;
  logic [REF_W-1:0]   in_stub_ref;

  assign in_op         = s_axis_tuser;
  assign in_index      = s_axis_tdata[15:0];
  assign in_merged_ref = s_axis_tdata[27:16];
  assign in_inv_pt     = s_axis_tdata[43:28];
  assign in_freq       = s_axis_tdata[67:44];
  assign in_tower      = s_axis_tdata[73:68];
  assign in_layer      = s_axis_tdata[76:74];
  assign in_stub_ref   = s_axis_tdata[88:77];

  logic acc;
  assign acc = s_axis_tvalid && s_axis_tready;

  // Slot to bitmap word and bit
  function automatic logic [OAW-1:0] slot_word(input logic [MW-1:0] s);
    logic [EW-1:0] e;
    e = EW'(s);
    return e[EW-1:OCC_BW];
  endfunction

  function automatic logic [OCC_BW-1:0] slot_bit(input logic [MW-1:0] s);
    logic [EW-1:0] e;
    e = EW'(s);
    return e[OCC_BW-1:0];
  endfunction

  // Control registers
  state_e             state_q, state_d;
  logic [MW-1:0]      cs_q, cs_d;
  logic               cur_valid_q, cur_valid_d;
  logic [DPW-1:0]     dp_q, dp_d;
  logic [OAW-1:0]     wptr_q, wptr_d;
  logic [OCC_BW-1:0]  lo_q, lo_d;
  logic               found_q, found_d;
  logic [MW-1:0]      s_q, s_d;
  logic               done_q, done_d;
  logic [LW-1:0]      lctr_q, lctr_d;
  logic [CW-1:0]      k_q, k_d;
  logic [TW-1:0]      rcnt_q, rcnt_d;
  logic [TW-1:0]      total_q, total_d;
  logic [OAW-1:0]     clr_q, clr_d;

  // Request payload held for multi-cycle ops
  logic [TOWER_W-1:0] tower_q;
  logic [LAYER_W-1:0] layer_q;
  logic [REF_W-1:0]   ref_q;

  // Memory ports
  logic               map_we, map_re;
  logic [MW-1:0]      map_rdata;
  logic               attr_we, attr_re;
  logic [ATTR_W-1:0]  attr_rdata;
  logic               twr_we, twr_re;
  logic [TOWER_W-1:0] twr_rdata;
  logic               occ_we, occ_re;
  logic [OAW-1:0]     occ_waddr, occ_raddr;
  logic [OCC_W-1:0]   occ_wdata, occ_rdata;
  logic               row_we, row_re;
  logic [RAW-1:0]     row_waddr, row_raddr;
  logic [RW-1:0]      row_wdata, row_rdata;

  rmsu_ram #(.WIDTH(MW), .DEPTH(PATTERN_DEPTH)) u_map (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (PAW'(in_index)),
    .wdata_i (MW'(in_merged_ref)),
    .re_i    (map_re),
    .raddr_i (PAW'(in_index)),
    .rdata_o (map_rdata)
  );

  rmsu_ram #(.WIDTH(ATTR_W), .DEPTH(MERGED_DEPTH)) u_attr (
    .clk_i   (clk_i),
    .we_i    (attr_we),
    .waddr_i (MW'(in_index)),
    .wdata_i ({in_freq, in_inv_pt}),
    .re_i    (attr_re),
    .raddr_i (s_q),
    .rdata_o (attr_rdata)
  );

  rmsu_ram #(.WIDTH(TOWER_W), .DEPTH(MERGED_DEPTH)) u_tower (
    .clk_i   (clk_i),
    .we_i    (twr_we),
    .waddr_i (cs_q),
    .wdata_i (tower_q),
    .re_i    (twr_re),
    .raddr_i (s_q),
    .rdata_o (twr_rdata)
  );

  rmsu_ram #(.WIDTH(OCC_W), .DEPTH(ODEPTH)) u_occ (
    .clk_i   (clk_i),
    .we_i    (occ_we),
    .waddr_i (occ_waddr),
    .wdata_i (occ_wdata),
    .re_i    (occ_re),
    .raddr_i (occ_raddr),
    .rdata_o (occ_rdata)
  );

  rmsu_ram #(.WIDTH(RW), .DEPTH(RDEPTH)) u_rows (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (row_waddr),
    .wdata_i (row_wdata),
    .re_i    (row_re),
    .raddr_i (row_raddr),
    .rdata_o (row_rdata)
  );

  // Bitmap scan: mask off bits below the start point
  logic [OCC_W-1:0]  one_w;
  logic [OCC_W-1:0]  masked;
  logic              ffs_found;
  logic [OCC_BW-1:0] ffs_idx;
  logic [OCC_W-1:0]  ffs_bit;
  logic [OCC_W-1:0]  rest;

  assign one_w  = OCC_W'(1);
  assign masked = occ_rdata & ~((one_w << lo_q) - one_w);

  rmsu_ffs u_ffs (
    .word_i  (masked),
    .found_o (ffs_found),
    .idx_o   (ffs_idx)
  );

  assign ffs_bit = one_w << ffs_idx;
  assign rest    = masked & ~(ffs_bit | (ffs_bit - one_w));

  // Row fields
  logic [CW-1:0] row_cnt;
  assign row_cnt = row_rdata[CW-1:0];

  // Output register
  logic                ov_q;
  logic                out_free, out_load;
  logic [REF_W-1:0]    o_merged_q;
  logic [TOWER_W-1:0]  o_tower_q;
  logic [NSTUBS_W-1:0] o_nstubs_q;
  logic [INVPT_W-1:0]  o_invpt_q;
  logic [FREQ_W-1:0]   o_freq_q;
  logic [LAYER_W-1:0]  o_layer_q;
  logic [REF_W-1:0]    o_ref_q;
  logic                o_sv_q, o_last_q, o_done_q;
  logic [REF_W-1:0]    ol_merged;
  logic [TOWER_W-1:0]  ol_tower;
  logic [NSTUBS_W-1:0] ol_nstubs;
  logic [INVPT_W-1:0]  ol_invpt;
  logic [FREQ_W-1:0]   ol_freq;
  logic [LAYER_W-1:0]  ol_layer;
  logic [REF_W-1:0]    ol_ref;
  logic                ol_sv, ol_last, ol_done;

  assign out_free = !ov_q || m_axis_tready;

  // Stub update scratch
  logic              dup;
  logic [CW-1:0]     ncnt;
  logic [TW-1:0]     tsum;

  // Sequencer: next state and memory controls
  always_comb begin
    state_d     = state_q;
    cs_d        = cs_q;
    cur_valid_d = cur_valid_q;
    dp_d        = dp_q;
    wptr_d      = wptr_q;
    lo_d        = lo_q;
    found_d     = found_q;
    s_d         = s_q;
    done_d      = done_q;
    lctr_d      = lctr_q;
    k_d         = k_q;
    rcnt_d      = rcnt_q;
    total_d     = total_q;
    clr_d       = clr_q;

    s_axis_tready = 1'b0;
    map_we  = 1'b0;
    map_re  = 1'b0;
    attr_we = 1'b0;
    attr_re = 1'b0;
    twr_we  = 1'b0;
    twr_re  = 1'b0;
    occ_we    = 1'b0;
    occ_waddr = '0;
    occ_wdata = '0;
    occ_re    = 1'b0;
    occ_raddr = '0;
    row_we    = 1'b0;
    row_waddr = '0;
    row_wdata = '0;
    row_re    = 1'b0;
    row_raddr = '0;

    out_load  = 1'b0;
    ol_merged = REF_W'(s_q);
    ol_tower  = twr_rdata;
    ol_nstubs = NSTUBS_W'(total_q);
    ol_invpt  = attr_rdata[INVPT_W-1:0];
    ol_freq   = attr_rdata[ATTR_W-1:INVPT_W];
    ol_layer  = '0;
    ol_ref    = '0;
    ol_sv     = 1'b0;
    ol_last   = 1'b0;
    ol_done   = done_q;

    dup  = 1'b0;
    ncnt = (row_cnt > CW'(MAX_STUBS)) ? CW'(MAX_STUBS) : row_cnt;
    tsum = total_q + TW'(row_cnt);

    unique case (state_q)
      // Bitmap clearing pass after reset or clear
      S_INIT: begin
        occ_we    = 1'b1;
        occ_waddr = clr_q;
        if (clr_q == OAW'(ODEPTH - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end

      // Take a request and dispatch
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (acc) begin
          case (in_op)
            OP_LOAD_MAP: begin
              map_we = 1'b1;
            end
            OP_LOAD_ATTR: begin
              attr_we = 1'b1;
            end
            OP_HEADER: begin
              map_re  = 1'b1;
              state_d = S_HDR_MAP;
            end
            OP_STUB: begin
              if ((4'(in_layer) < 4'(LAYERS)) && cur_valid_q) begin
                row_re    = 1'b1;
                row_raddr = {cs_q, LW'(in_layer)};
                state_d   = S_STUB;
              end
            end
            OP_DRAIN: begin
              if (dp_q == DPW'(MERGED_DEPTH)) begin
                state_d = S_NONE;
              end else begin
                occ_re    = 1'b1;
                occ_raddr = slot_word(MW'(dp_q));
                wptr_d    = slot_word(MW'(dp_q));
                lo_d      = slot_bit(MW'(dp_q));
                found_d   = 1'b0;
                state_d   = S_SCAN;
              end
            end
            OP_CLEAR: begin
              cur_valid_d = 1'b0;
              cs_d        = '0;
              dp_d        = '0;
              clr_d       = '0;
              state_d     = S_INIT;
            end
            default: begin
            end
          endcase
        end
      end

      // Header: merged index known, fetch its bitmap word
      S_HDR_MAP: begin
        cs_d        = map_rdata;
        cur_valid_d = 1'b1;
        occ_re      = 1'b1;
        occ_raddr   = slot_word(map_rdata);
        state_d     = S_HDR_OCC;
      end

      // Header: open the slot if it is new
      S_HDR_OCC: begin
        if (occ_rdata[slot_bit(cs_q)]) begin
          state_d = S_IDLE;
        end else begin
          occ_we    = 1'b1;
          occ_waddr = slot_word(cs_q);
          occ_wdata = occ_rdata | (one_w << slot_bit(cs_q));
          twr_we    = 1'b1;
          lctr_d    = '0;
          state_d   = S_HDR_CLR;
        end
      end

      // Header: empty the per-layer lists of a new slot
      S_HDR_CLR: begin
        row_we    = 1'b1;
        row_waddr = {cs_q, lctr_q};
        if (lctr_q == LW'(LAYERS - 1)) begin
          state_d = S_IDLE;
        end else begin
          lctr_d = lctr_q + 1'b1;
        end
      end

      // Stub: duplicate check, append or shift out the oldest
      S_STUB: begin
        for (int k = 0; k < MAX_STUBS; k++) begin
          if ((CW'(k) < ncnt) && (row_rdata[CW + k*REF_W +: REF_W] == ref_q)) begin
            dup = 1'b1;
          end
        end
        row_waddr = {cs_q, LW'(layer_q)};
        row_wdata = row_rdata;
        if (ncnt < CW'(MAX_STUBS)) begin
          row_wdata[CW-1:0] = ncnt + 1'b1;
          for (int k = 0; k < MAX_STUBS; k++) begin
            if (CW'(k) == ncnt) begin
              row_wdata[CW + k*REF_W +: REF_W] = ref_q;
            end
          end
        end else begin
          for (int k = 0; k < MAX_STUBS - 1; k++) begin
            row_wdata[CW + k*REF_W +: REF_W] = row_rdata[CW + (k+1)*REF_W +: REF_W];
          end
          row_wdata[CW + (MAX_STUBS-1)*REF_W +: REF_W] = ref_q;
        end
        row_we  = !dup;
        state_d = S_IDLE;
      end

      // Drain: find the next occupied slot, then whether another follows
      S_SCAN: begin
        if (!found_q) begin
          if (ffs_found) begin
            s_d     = MW'({wptr_q, ffs_idx});
            dp_d    = DPW'({wptr_q, ffs_idx}) + 1'b1;
            found_d = 1'b1;
            if (rest != '0) begin
              done_d  = 1'b0;
              state_d = S_FETCH;
            end else if (wptr_q == OAW'(ODEPTH - 1)) begin
              done_d  = 1'b1;
              state_d = S_FETCH;
            end else begin
              wptr_d    = wptr_q + 1'b1;
              lo_d      = '0;
              occ_re    = 1'b1;
              occ_raddr = wptr_q + 1'b1;
            end
          end else if (wptr_q == OAW'(ODEPTH - 1)) begin
            dp_d    = DPW'(MERGED_DEPTH);
            state_d = S_NONE;
          end else begin
            wptr_d    = wptr_q + 1'b1;
            lo_d      = '0;
            occ_re    = 1'b1;
            occ_raddr = wptr_q + 1'b1;
          end
        end else begin
          if (masked != '0) begin
            done_d  = 1'b0;
            state_d = S_FETCH;
          end else if (wptr_q == OAW'(ODEPTH - 1)) begin
            done_d  = 1'b1;
            state_d = S_FETCH;
          end else begin
            wptr_d    = wptr_q + 1'b1;
            lo_d      = '0;
            occ_re    = 1'b1;
            occ_raddr = wptr_q + 1'b1;
          end
        end
      end

      // Drain: read attributes, tower and first row
      S_FETCH: begin
        attr_re   = 1'b1;
        twr_re    = 1'b1;
        row_re    = 1'b1;
        row_raddr = {s_q, LW'(0)};
        lctr_d    = '0;
        total_d   = '0;
        state_d   = S_SUM;
      end

      // Drain: sum the per-layer counts
      S_SUM: begin
        total_d = tsum;
        row_re  = 1'b1;
        if (lctr_q != LW'(LAYERS - 1)) begin
          row_raddr = {s_q, lctr_q + 1'b1};
          lctr_d    = lctr_q + 1'b1;
        end else begin
          row_raddr = {s_q, LW'(0)};
          lctr_d    = '0;
          k_d       = '0;
          rcnt_d    = '0;
          state_d   = (tsum == '0) ? S_EMPTY : S_EMIT;
        end
      end

      // Drain: one result per stored stub
      S_EMIT: begin
        if (k_q < ncnt) begin
          ol_layer = LAYER_W'(lctr_q);
          ol_ref   = row_rdata[CW + int'(k_q)*REF_W +: REF_W];
          ol_sv    = 1'b1;
          ol_last  = ((rcnt_q + 1'b1) == total_q);
          if (out_free) begin
            out_load = 1'b1;
            rcnt_d   = rcnt_q + 1'b1;
            k_d      = k_q + 1'b1;
            if (ol_last) begin
              state_d = S_IDLE;
            end
          end
        end else begin
          row_re    = 1'b1;
          row_raddr = {s_q, lctr_q + 1'b1};
          lctr_d    = lctr_q + 1'b1;
          k_d       = '0;
        end
      end

      // Drain: occupied slot without stubs
      S_EMPTY: begin
        ol_last = 1'b1;
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      // Drain: nothing left
      S_NONE: begin
        ol_merged = '0;
        ol_tower  = '0;
        ol_nstubs = '0;
        ol_invpt  = '0;
        ol_freq   = '0;
        ol_last   = 1'b1;
        ol_done   = 1'b1;
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      cs_q        <= '0;
      cur_valid_q <= 1'b0;
      dp_q        <= '0;
      wptr_q      <= '0;
      lo_q        <= '0;
      found_q     <= 1'b0;
      s_q         <= '0;
      done_q      <= 1'b0;
      lctr_q      <= '0;
      k_q         <= '0;
      rcnt_q      <= '0;
      total_q     <= '0;
      clr_q       <= '0;
      ov_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      cs_q        <= cs_d;
      cur_valid_q <= cur_valid_d;
      dp_q        <= dp_d;
      wptr_q      <= wptr_d;
      lo_q        <= lo_d;
      found_q     <= found_d;
      s_q         <= s_d;
      done_q      <= done_d;
      lctr_q      <= lctr_d;
      k_q         <= k_d;
      rcnt_q      <= rcnt_d;
      total_q     <= total_d;
      clr_q       <= clr_d;
      if (out_load) begin
        ov_q <= 1'b1;
      end else if (m_axis_tready) begin
        ov_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (acc) begin
      tower_q <= in_tower;
      layer_q <= in_layer;
      ref_q   <= in_stub_ref;
    end
    if (out_load) begin
      o_merged_q <= ol_merged;
      o_tower_q  <= ol_tower;
      o_nstubs_q <= ol_nstubs;
      o_invpt_q  <= ol_invpt;
      o_freq_q   <= ol_freq;
      o_layer_q  <= ol_layer;
      o_ref_q    <= ol_ref;
      o_sv_q     <= ol_sv;
      o_last_q   <= ol_last;
      o_done_q   <= ol_done;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {2'b00, o_ref_q, o_layer_q, o_freq_q, o_invpt_q,
                          o_nstubs_q, o_tower_q, o_merged_q};
  assign m_axis_tuser  = {o_done_q, o_sv_q};
  assign m_axis_tlast  = o_last_q;

`ifndef SYNTH
  // A result without a stub always ends its drain
  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> m_axis_tlast)
    else $error("stubless result not marked last");

  // Emission never passes the stored stub total
  a_emit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> ((rcnt_q < total_q) && (lctr_q < LW'(LAYERS))))
    else $error("drain emitted past stub total");

  // Clear drops the current slot
  a_clear_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && (in_op == OP_CLEAR)) |=> (!cur_valid_q && (dp_q == '0)))
    else $error("clear left slot selected");

  // Drain pointer stays within range
  a_dp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_q <= DPW'(MERGED_DEPTH))
    else $error("drain pointer out of range");
`endif

endmodule
